FILE: rtl/decision_tree_leaf_splitter_defines.svh
// ----------------------------------------------------------------------------
// Decision tree leaf splitter: assertion macros
// Shared property wrappers for the checker. Every property is clocked on clk
// and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DECISION_TREE_LEAF_SPLITTER_DEFINES_SVH
`define DECISION_TREE_LEAF_SPLITTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTLS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dtls_pkg.sv
// ----------------------------------------------------------------------------
// Decision tree leaf splitter package
// Sizes, word layouts, status codes and the control/status bundles shared by
// the controller and the datapath.
// ----------------------------------------------------------------------------
package dtls_pkg;

    // Tree capacity.
    localparam int MAX_VERTICES = 255;
    localparam int INTERIOR_CAP = MAX_VERTICES / 2 + 1;
    localparam int VTX_W        = 8;
    localparam int INT_W        = 7;
    localparam int VTX_DEPTH    = 1 << VTX_W;
    localparam int INT_DEPTH    = 1 << INT_W;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NOT_LEAF = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_RANGE    = 2'd3
    } status_code_t;

    // Input word, vertex_index in the lowest bits.
    typedef struct packed {
        logic [31:0] right_leaf_value;
        logic [31:0] left_leaf_value;
        logic [31:0] split_threshold;
        logic [7:0]  feature_index;
        logic [7:0]  vertex_index;
    } in_item_t;

    // Result word, the slot of the split vertex in the lowest bits.
    typedef struct packed {
        logic [31:0] read_threshold;
        logic [7:0]  read_feature;
        logic [7:0]  read_right_child;
        logic [7:0]  read_left_child;
        logic        read_is_interior;
        logic [31:0] read_value;
        logic [8:0]  read_parent;
        logic [6:0]  interior_count;
        logic [7:0]  vertex_count;
        logic [7:0]  first_child_index;
        logic [6:0]  split_slot;
    } out_item_t;

    localparam int IN_DATA_W  = $bits(in_item_t);
    localparam int OUT_DATA_W = $bits(out_item_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic fetch;
        logic swap_a;
        logic swap_b;
        logic append;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic split_ok;
        logic need_swap;
    } dp_status_t;

endpackage

FILE: rtl/dtls_ctrl.sv
// ----------------------------------------------------------------------------
// Decision tree leaf splitter controller
// Sequences one word through fetch, for a valid split the optional swap A
// step, swap B and append, and the hand-over into the output register.
// ----------------------------------------------------------------------------
module dtls_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  dtls_pkg::dp_status_t stat,
    output dtls_pkg::dp_cmd_t    cmd
);
    import dtls_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_FETCH  = 6'b000010,
        ST_SWAP_A = 6'b000100,
        ST_SWAP_B = 6'b001000,
        ST_APPEND = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   load;

    // The output register is free when empty or being emptied this cycle.
    assign load = (state_reg == ST_RESULT) && (!out_valid_reg || out_ready);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (stat.is_read || !stat.split_ok)
                begin
                    state_next = ST_RESULT;
                end
                else if (stat.need_swap)
                begin
                    state_next = ST_SWAP_A;
                end
                else
                begin
                    state_next = ST_SWAP_B;
                end
            end
            ST_SWAP_A: state_next = ST_SWAP_B;
            ST_SWAP_B: state_next = ST_APPEND;
            ST_APPEND: state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Commands.
    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign cmd.accept   = (state_reg == ST_IDLE) && in_valid;
    assign cmd.fetch    = (state_reg == ST_FETCH);
    assign cmd.swap_a   = (state_reg == ST_SWAP_A);
    assign cmd.swap_b   = (state_reg == ST_SWAP_B);
    assign cmd.append   = (state_reg == ST_APPEND);
    assign cmd.load_out = load;

endmodule

FILE: rtl/dtls_datapath.sv
// ----------------------------------------------------------------------------
// Decision tree leaf splitter datapath
// Holds the tree stores, the size counters and the root value register, and
// builds the result word.
// ----------------------------------------------------------------------------
module dtls_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [dtls_pkg::IN_DATA_W-1:0]      in_data,
    input  logic                                in_mode,
    input  logic                                cfg_write,
    input  logic [31:0]                         cfg_data,
    input  dtls_pkg::dp_cmd_t                   cmd,
    output dtls_pkg::dp_status_t                stat,
    output logic [dtls_pkg::OUT_DATA_W-1:0]     res_data,
    output logic [1:0]                          res_user
);
    import dtls_pkg::*;

    // Point the child link that names 'from' at 'to'; otherwise the second.
    function automatic logic [2*VTX_W-1:0] relink(input logic [2*VTX_W-1:0] links,
                                                   input logic [VTX_W-1:0]   from,
                                                   input logic [VTX_W-1:0]   to);
        logic [2*VTX_W-1:0] r;
        r = links;
        if (links[VTX_W-1:0] == from)
        begin
            r[VTX_W-1:0] = to;
        end
        else
        begin
            r[2*VTX_W-1:VTX_W] = to;
        end
        return r;
    endfunction

    in_item_t item;

    // Latched item and sizes at acceptance.
    logic               mode_reg;
    logic [VTX_W-1:0]   idx_reg;
    logic [7:0]         feat_reg;
    logic [31:0]        thr_reg;
    logic [31:0]        left_reg;
    logic [31:0]        right_reg;
    logic [INT_W-1:0]   slot_reg;
    logic [VTX_W-1:0]   c0_reg;

    // Tree size and root value.
    logic [VTX_W-1:0]   vc_reg;
    logic [INT_W-1:0]   ic_reg;
    logic [31:0]        root_reg;

    // Stores.
    logic [VTX_W-1:0]   parent_mem [VTX_DEPTH];
    logic [31:0]        value_mem  [VTX_DEPTH];
    logic [2*VTX_W-1:0] child_mem  [INT_DEPTH];
    logic [39:0]        rule_mem   [INT_DEPTH];

    // Registered read data.
    logic [VTX_W-1:0]   pa_rd;
    logic [VTX_W-1:0]   pb_rd;
    logic [31:0]        va_rd;
    logic [31:0]        vb_rd;
    logic [2*VTX_W-1:0] child_a_rd;
    logic [2*VTX_W-1:0] child_b_rd;
    logic [39:0]        rule_rd;
    logic [2*VTX_W-1:0] link_a_reg;

    // Write ports.
    logic               par_we;
    logic [VTX_W-1:0]   par_wa;
    logic [VTX_W-1:0]   par_wd;
    logic               val_we;
    logic [VTX_W-1:0]   val_wa;
    logic [31:0]        val_wd;
    logic               chd_we;
    logic [INT_W-1:0]   chd_wa;
    logic [2*VTX_W-1:0] chd_wd;
    logic               chd_ra_en;
    logic [INT_W-1:0]   chd_ra;

    // Checks and derived values.
    logic               not_leaf;
    logic               full;
    logic               out_range;
    logic               swap;
    logic               swap_fetch;
    logic [2*VTX_W-1:0] link_a;
    logic [2*VTX_W-1:0] link_b;
    logic [VTX_W-1:0]   slot_vtx;
    logic [VTX_W-1:0]   c1;
    status_code_t       code;
    out_item_t          res_next;
    out_item_t          res_reg;
    status_code_t       res_code_reg;

    assign item     = in_item_t'(in_data);
    assign slot_vtx = {1'b0, slot_reg};
    assign c1       = c0_reg + 8'd1;

    // Leaf, capacity and range checks on the latched item.
    assign out_range = (idx_reg >= vc_reg);
    assign not_leaf  = out_range || (idx_reg < slot_vtx);
    assign full      = (({1'b0, c0_reg} + 9'd2) > 9'(MAX_VERTICES))
                    || ({1'b0, slot_reg} >= 8'(INTERIOR_CAP));
    assign swap      = (idx_reg != slot_vtx);

    always_comb
    begin
        if (mode_reg)
        begin
            code = out_range ? STATUS_RANGE : STATUS_OK;
        end
        else if (not_leaf)
        begin
            code = STATUS_NOT_LEAF;
        end
        else if (full)
        begin
            code = STATUS_FULL;
        end
        else
        begin
            code = STATUS_OK;
        end
    end

    assign stat.is_read   = mode_reg;
    assign stat.split_ok  = !mode_reg && !not_leaf && !full;
    assign stat.need_swap = swap;
    assign swap_fetch     = cmd.fetch && stat.split_ok && swap;

    // Latch the item and the sizes it starts from.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg  <= in_mode;
            idx_reg   <= item.vertex_index;
            feat_reg  <= item.feature_index;
            thr_reg   <= item.split_threshold;
            left_reg  <= item.left_leaf_value;
            right_reg <= item.right_leaf_value;
            slot_reg  <= ic_reg;
            c0_reg    <= vc_reg;
        end
    end

    // Sizes and root value: a configuration write restarts the tree.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg   <= 8'd1;
            ic_reg   <= '0;
            root_reg <= '0;
        end
        else if (cfg_write)
        begin
            vc_reg   <= 8'd1;
            ic_reg   <= '0;
            root_reg <= cfg_data;
        end
        else if (cmd.append)
        begin
            vc_reg <= c0_reg + 8'd2;
            ic_reg <= slot_reg + 7'd1;
        end
    end

    // Relinked child entries of the two parents. When both leaves share a
    // parent, the second relink works on the entry the first one wrote.
    assign link_a = relink(child_a_rd, idx_reg, slot_vtx);
    assign link_b = relink((pb_rd == pa_rd) ? link_a_reg : child_b_rd, slot_vtx, idx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.swap_a)
        begin
            link_a_reg <= link_a;
        end
    end

    // Write port selection for the parent and value stores.
    always_comb
    begin
        par_we = 1'b0;
        par_wa = idx_reg;
        par_wd = pb_rd;
        val_we = 1'b0;
        val_wa = idx_reg;
        val_wd = vb_rd;
        if (swap_fetch)
        begin
            par_we = 1'b1;
            val_we = 1'b1;
        end
        else if (cmd.swap_a)
        begin
            par_we = 1'b1;
            par_wa = slot_vtx;
            par_wd = pa_rd;
            val_we = 1'b1;
            val_wa = slot_vtx;
            val_wd = va_rd;
        end
        else if (cmd.swap_b)
        begin
            par_we = 1'b1;
            par_wa = c0_reg;
            par_wd = slot_vtx;
            val_we = 1'b1;
            val_wa = c0_reg;
            val_wd = left_reg;
        end
        else if (cmd.append)
        begin
            par_we = 1'b1;
            par_wa = c1;
            par_wd = slot_vtx;
            val_we = 1'b1;
            val_wa = c1;
            val_wd = right_reg;
        end
    end

    // Write port selection for the child store.
    always_comb
    begin
        chd_we = 1'b0;
        chd_wa = pa_rd[INT_W-1:0];
        chd_wd = link_a;
        if (cmd.swap_a)
        begin
            chd_we = 1'b1;
        end
        else if (cmd.swap_b && swap)
        begin
            chd_we = 1'b1;
            chd_wa = pb_rd[INT_W-1:0];
            chd_wd = link_b;
        end
        else if (cmd.append)
        begin
            chd_we = 1'b1;
            chd_wa = slot_reg;
            chd_wd = {c1, c0_reg};
        end
    end

    assign chd_ra_en = cmd.accept || swap_fetch;
    assign chd_ra    = cmd.accept ? item.vertex_index[INT_W-1:0] : pa_rd[INT_W-1:0];

    // Parent and value stores: two reads at acceptance, one write a cycle.
    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            parent_mem[par_wa] <= par_wd;
        end
        if (val_we)
        begin
            value_mem[val_wa] <= val_wd;
        end
        if (cmd.accept)
        begin
            pa_rd <= parent_mem[item.vertex_index];
            pb_rd <= parent_mem[{1'b0, ic_reg}];
            va_rd <= value_mem[item.vertex_index];
            vb_rd <= value_mem[{1'b0, ic_reg}];
        end
    end

    // Child store: the first port serves reads and the first parent, the
    // second port the other parent.
    always_ff @(posedge clk)
    begin
        if (chd_we)
        begin
            child_mem[chd_wa] <= chd_wd;
        end
        if (chd_ra_en)
        begin
            child_a_rd <= child_mem[chd_ra];
        end
        if (swap_fetch)
        begin
            child_b_rd <= child_mem[pb_rd[INT_W-1:0]];
        end
    end

    // Rule store: threshold above feature.
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            rule_mem[slot_reg] <= {thr_reg, feat_reg};
        end
        if (cmd.accept)
        begin
            rule_rd <= rule_mem[item.vertex_index[INT_W-1:0]];
        end
    end

    // Result word. Vertex zero reads its value from the root value register.
    always_comb
    begin
        res_next                = '0;
        res_next.vertex_count   = vc_reg;
        res_next.interior_count = ic_reg;
        if (!mode_reg && (code == STATUS_OK))
        begin
            res_next.split_slot        = slot_reg;
            res_next.first_child_index = c0_reg;
        end
        if (mode_reg && (code == STATUS_OK))
        begin
            res_next.read_parent = (idx_reg == '0) ? 9'h1FF : {1'b0, pa_rd};
            res_next.read_value  = (idx_reg == '0) ? root_reg : va_rd;
            if (idx_reg < {1'b0, ic_reg})
            begin
                res_next.read_is_interior = 1'b1;
                res_next.read_left_child  = child_a_rd[VTX_W-1:0];
                res_next.read_right_child = child_a_rd[2*VTX_W-1:VTX_W];
                res_next.read_feature     = rule_rd[7:0];
                res_next.read_threshold   = rule_rd[39:8];
            end
        end
    end

    // The status code is taken in fetch, before the sizes move on.
    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            res_code_reg <= code;
        end
        if (cmd.load_out)
        begin
            res_reg <= res_next;
        end
    end

    // Status of the word in the output register.
    logic [1:0] out_code_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_code_reg <= res_code_reg;
        end
    end

    assign res_data = res_reg;
    assign res_user = out_code_reg;

endmodule

FILE: rtl/decision_tree_leaf_splitter.sv
// ----------------------------------------------------------------------------
// Decision tree leaf splitter
// Channel   Direction  Word
// s_axis    in         tuser: mode; tdata: vertex, feature, threshold, values
// m_axis    out        tuser: status; tdata: split indices, sizes, vertex read
// cfg       in         data: root_value, restarts the tree
//
// A read runs through fetch and result, a split at the next interior slot
// through fetch, swap B, append and result, and one that first trades places
// with that slot also through swap A, as each store has a single write port.
// The output register lets a new word enter while the last result waits.
// Reset and a configuration write leave a tree of one root leaf.
// ----------------------------------------------------------------------------
module decision_tree_leaf_splitter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // vertex_index, feature_index, split_threshold, left_leaf_value,
    // right_leaf_value
    input  logic [dtls_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // mode
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // split_slot, first_child_index, vertex_count, interior_count,
    // read_parent, read_value, read_is_interior, read_left_child,
    // read_right_child, read_feature, read_threshold
    output logic [dtls_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status
    output logic [1:0]                          m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [31:0]                         cfg_data
);
    import dtls_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    // The user must send configuration writes only while idle; not enforced here.
    assign cfg_ready = 1'b1;

    dtls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dtls_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .in_mode   (s_axis_tuser),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .res_data  (m_axis_tdata),
        .res_user  (m_axis_tuser)
    );

endmodule

FILE: rtl/dtls_checker.sv
// ----------------------------------------------------------------------------
// Decision tree leaf splitter checker
// Port-level properties of the splitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "decision_tree_leaf_splitter_defines.svh"

module dtls_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [dtls_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input logic [1:0]                          m_axis_tuser
);
    import dtls_pkg::*;

    out_item_t             res;
    logic [OUT_DATA_W+1:0] out_word;
    logic                  out_wait;
    logic                  in_take;
    logic                  range_err;
    logic                  size_ok;
    logic                  res_empty;

    // Views of the result channel used by the properties below.
    assign res       = out_item_t'(m_axis_tdata);
    assign out_word  = {m_axis_tuser, m_axis_tdata};
    assign out_wait  = m_axis_tvalid && !m_axis_tready;
    assign in_take   = s_axis_tvalid && s_axis_tready;
    assign range_err = m_axis_tvalid && (m_axis_tuser == STATUS_RANGE);
    assign size_ok   = res.vertex_count[0] && (res.vertex_count[7:1] == res.interior_count);
    assign res_empty = (m_axis_tdata[OUT_DATA_W-1:30] == '0) && (m_axis_tdata[14:0] == '0);

    // A held result word does not change.
    `DTLS_ASSERT_NEXT(a_out_hold, out_wait, m_axis_tvalid && $stable(out_word), "held result changed")

    // Each accepted word is worked on before another is taken.
    `DTLS_ASSERT_NEXT(a_one_at_a_time, in_take, !s_axis_tready, "second word taken while busy")

    // Every vertex but the root comes in a pair of children.
    `DTLS_ASSERT_SAME(a_size_pairs, m_axis_tvalid, size_ok, "vertex and interior counts disagree")

    // A read out of range returns no vertex contents.
    `DTLS_ASSERT_SAME(a_range_empty, range_err, res_empty, "range error carries data")

endmodule

bind decision_tree_leaf_splitter dtls_checker u_dtls_checker (.*);

FILE: bench/decision_tree_leaf_splitter_tb.sv
// ----------------------------------------------------------------------------
// Decision tree leaf splitter testbench
// Drives split and read words into the splitter and keeps its own mirror of
// the tree, updated on every accepted request word. Each result word is
// checked field by field against the oldest prediction. Root value writes
// restart the tree between phases. Random phases mostly split real leaves, so
// the tree grows until it is full, mixed with reads and words carrying
// arbitrary indices.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decision_tree_leaf_splitter_tb;
    import dtls_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 220;
    localparam int DRAIN_CYCLES = 20;

    localparam logic MODE_SPLIT = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // One predicted result: the data word and its status.
    typedef struct {
        out_item_t    word;
        status_code_t status;
    } tree_reply_t;

    // Mirror of the tree and the queue of predicted replies.
    class tree_mirror;
        logic [31:0] root_value;
        logic [7:0]  parent_of [VTX_DEPTH];
        logic [31:0] value_of [VTX_DEPTH];
        logic [7:0]  left_of [INT_DEPTH];
        logic [7:0]  right_of [INT_DEPTH];
        logic [7:0]  feature_of [INT_DEPTH];
        logic [31:0] threshold_of [INT_DEPTH];
        int          vertices;
        int          interiors;
        int          mismatches;
        tree_reply_t awaited_replies[$];

        function new();
            root_value = '0;
            mismatches = 0;
            restart();
        endfunction

        // Back to a single root leaf holding the root value.
        function void restart();
            foreach (parent_of[i])
            begin
                parent_of[i] = '0;
                value_of[i] = '0;
            end
            foreach (left_of[i])
            begin
                left_of[i] = '0;
                right_of[i] = '0;
                feature_of[i] = '0;
                threshold_of[i] = '0;
            end
            value_of[0] = root_value;
            vertices = 1;
            interiors = 0;
        endfunction

        function void write_root(logic [31:0] value);
            root_value = value;
            restart();
        endfunction

        // Point whichever child link of p names 'from' at 'to'.
        function void relink(int p, int from, int to);
            if (p >= INTERIOR_CAP)
                return;
            if (left_of[p] == from[7:0])
                left_of[p] = to[7:0];
            else
                right_of[p] = to[7:0];
        endfunction

        function tree_reply_t predict_reply(logic mode, in_item_t req);
            tree_reply_t rep;
            int          idx;
            int          slot;
            int          first;
            int          pa;
            int          pb;
            logic [7:0]  tmp_parent;
            logic [31:0] tmp_value;

            rep.word = '0;
            rep.status = STATUS_OK;
            idx = req.vertex_index;
            if (mode == MODE_SPLIT)
            begin
                if (idx >= vertices || idx < interiors)
                    rep.status = STATUS_NOT_LEAF;
                else if (vertices + 2 > MAX_VERTICES || interiors >= INTERIOR_CAP)
                    rep.status = STATUS_FULL;
                else
                begin
                    slot = interiors;
                    first = vertices;
                    // A leaf past the next interior slot trades places with it.
                    if (idx != slot)
                    begin
                        pa = parent_of[idx];
                        pb = parent_of[slot];
                        relink(pa, idx, slot);
                        relink(pb, slot, idx);
                        tmp_parent = parent_of[idx];
                        parent_of[idx] = parent_of[slot];
                        parent_of[slot] = tmp_parent;
                        tmp_value = value_of[idx];
                        value_of[idx] = value_of[slot];
                        value_of[slot] = tmp_value;
                    end
                    value_of[first] = req.left_leaf_value;
                    value_of[first + 1] = req.right_leaf_value;
                    parent_of[first] = slot[7:0];
                    parent_of[first + 1] = slot[7:0];
                    left_of[slot] = first[7:0];
                    right_of[slot] = 8'(first + 1);
                    feature_of[slot] = req.feature_index;
                    threshold_of[slot] = req.split_threshold;
                    vertices = first + 2;
                    interiors = slot + 1;
                    rep.word.split_slot = slot[6:0];
                    rep.word.first_child_index = first[7:0];
                end
            end
            else
            begin
                if (idx >= vertices)
                    rep.status = STATUS_RANGE;
                else
                begin
                    rep.word.read_parent = (idx == 0) ? 9'h1FF : {1'b0, parent_of[idx]};
                    rep.word.read_value = value_of[idx];
                    if (idx < interiors && idx < INTERIOR_CAP)
                    begin
                        rep.word.read_is_interior = 1'b1;
                        rep.word.read_left_child = left_of[idx];
                        rep.word.read_right_child = right_of[idx];
                        rep.word.read_feature = feature_of[idx];
                        rep.word.read_threshold = threshold_of[idx];
                    end
                end
            end
            rep.word.vertex_count = vertices[7:0];
            rep.word.interior_count = interiors[6:0];
            return rep;
        endfunction

        function void note_request(logic mode, in_item_t req);
            awaited_replies.insert(awaited_replies.size(), predict_reply(mode, req));
        endfunction

        function void check_field(string name, logic [31:0] exp, logic [31:0] act);
            if (act !== exp)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
                mismatches++;
            end
        endfunction

        function void check_reply(out_item_t got, logic [1:0] got_status);
            tree_reply_t exp;

            if (awaited_replies.size() == 0)
            begin
                $error("result word with no request outstanding");
                mismatches++;
                return;
            end
            exp = awaited_replies.pop_front();
            check_field("status", exp.status, got_status);
            check_field("split_slot", exp.word.split_slot, got.split_slot);
            check_field("first_child_index", exp.word.first_child_index,
                        got.first_child_index);
            check_field("vertex_count", exp.word.vertex_count, got.vertex_count);
            check_field("interior_count", exp.word.interior_count, got.interior_count);
            check_field("read_parent", exp.word.read_parent, got.read_parent);
            check_field("read_value", exp.word.read_value, got.read_value);
            check_field("read_is_interior", exp.word.read_is_interior,
                        got.read_is_interior);
            check_field("read_left_child", exp.word.read_left_child,
                        got.read_left_child);
            check_field("read_right_child", exp.word.read_right_child,
                        got.read_right_child);
            check_field("read_feature", exp.word.read_feature, got.read_feature);
            check_field("read_threshold", exp.word.read_threshold, got.read_threshold);
        endfunction

        function int outstanding();
            return awaited_replies.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [31:0]           cfg_data;

    tree_mirror tree = new();
    bit         hold_request = 1'b0;
    int         cycle_count = 0;

    decision_tree_leaf_splitter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Watch all three channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tree.write_root(cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                tree.note_request(s_axis_tuser, in_item_t'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
                tree.check_reply(out_item_t'(m_axis_tdata), m_axis_tuser);
        end
    end

    // Receiver: stall patterns of random length, and a long hold-off on demand.
    initial
    begin : receiver
        int style;
        int span;

        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            style = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_request)
                begin
                    hold_request = 1'b0;
                    m_axis_tready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                case (style)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = 1'($urandom_range(0, 1));
                    2: m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Give up if the run goes on far longer than any correct run could.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("decision_tree_leaf_splitter_tb NOT OK");
        $finish;
    end

    // Offer one word and hold it until accepted; returns at a falling edge.
    task automatic send_word(logic mode, in_item_t req);
        s_axis_tuser = mode;
        s_axis_tdata = req;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic pause(int n);
        s_axis_tvalid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (tree.outstanding() != 0)
            @(negedge clk);
    endtask

    // Root value write, only while the block is idle.
    task automatic write_root(logic [31:0] value);
        wait_drained();
        cfg_data = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_fields(logic mode, int idx, int feat, logic [31:0] thr,
                               logic [31:0] lv, logic [31:0] rv);
        in_item_t req;

        req.vertex_index = idx[7:0];
        req.feature_index = feat[7:0];
        req.split_threshold = thr;
        req.left_leaf_value = lv;
        req.right_leaf_value = rv;
        send_word(mode, req);
    endtask

    // Mostly splits of real leaves and reads of real vertices, some noise.
    task automatic send_random();
        in_item_t req;
        logic     mode;
        int       kind;

        kind = $urandom_range(0, 99);
        req.feature_index = 8'($urandom_range(0, 255));
        req.split_threshold = $urandom();
        req.left_leaf_value = $urandom();
        req.right_leaf_value = $urandom();
        if (kind < 55)
        begin
            mode = MODE_SPLIT;
            req.vertex_index = 8'($urandom_range(tree.interiors, tree.vertices - 1));
        end
        else if (kind < 85)
        begin
            mode = MODE_READ;
            req.vertex_index = 8'($urandom_range(0, tree.vertices - 1));
        end
        else
        begin
            mode = 1'($urandom_range(0, 1));
            req.vertex_index = 8'($urandom_range(0, 255));
        end
        send_word(mode, req);
    endtask

    // One tree lifetime: restart, then bursts with gaps until the count is sent.
    task automatic run_phase(logic [31:0] root, int count, bit pressure);
        int sent;
        int burst;
        int gap_kind;

        sent = 0;
        write_root(root);
        if (pressure)
        begin
            // Receiver stops while words keep coming, so the block backs up.
            hold_request = 1'b1;
            repeat (60) send_random();
            sent = 60;
        end
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst) send_random();
            sent += burst;
            gap_kind = $urandom_range(0, 99);
            if (gap_kind < 40)
                ;
            else if (gap_kind < 85)
                pause($urandom_range(1, 6));
            else if (gap_kind < 95)
                pause($urandom_range(20, 40));
            else
                wait_drained();
        end
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, both modes, every status but full, and both kinds of swap.
        write_root(32'h8000_0000);
        send_fields(MODE_READ, 0, 0, '0, '0, '0);
        send_fields(MODE_READ, 1, 0, '0, '0, '0);
        send_fields(MODE_READ, 255, 255, '1, '1, '1);
        send_fields(MODE_SPLIT, 1, 0, '0, '0, '0);
        send_fields(MODE_SPLIT, 0, 255, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_fields(MODE_SPLIT, 0, 1, '0, '0, '0);
        // Sibling leaf past the next slot: both share the root as parent.
        send_fields(MODE_SPLIT, 2, 0, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_fields(MODE_READ, 0, 0, '0, '0, '0);
        send_fields(MODE_READ, 1, 0, '0, '0, '0);
        send_fields(MODE_READ, 2, 0, '0, '0, '0);
        send_fields(MODE_READ, 3, 0, '0, '0, '0);
        send_fields(MODE_READ, 4, 0, '0, '0, '0);
        // Leaf with a different parent from the vertex in the next slot.
        send_fields(MODE_SPLIT, 4, 170, 32'h5555_AAAA, 32'hAAAA_5555, 32'h0001_0000);
        send_fields(MODE_READ, 1, 0, '0, '0, '0);
        send_fields(MODE_READ, 2, 0, '0, '0, '0);
        send_fields(MODE_READ, 4, 0, '0, '0, '0);
        send_fields(MODE_READ, 6, 0, '0, '0, '0);
        send_fields(MODE_READ, 7, 0, '0, '0, '0);
        send_fields(MODE_SPLIT, 255, 0, '1, '1, '1);
        wait_drained();

        // Random phases; each lasts long enough to fill the tree.
        run_phase(32'h0000_0000, 300, 1'b1);
        run_phase(32'h7FFF_FFFF, 280, 1'b0);
        run_phase($urandom(), 260, 1'b0);
        run_phase(32'hFFFF_FFFF, 280, 1'b0);
        run_phase(32'h0001_0000, 280, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (tree.mismatches == 0 && tree.outstanding() == 0)
            $display("decision_tree_leaf_splitter_tb OK");
        else
            $display("decision_tree_leaf_splitter_tb NOT OK");
        $finish;
    end

endmodule

FILE: decision_tree_leaf_splitter.f
+incdir+rtl
rtl/dtls_pkg.sv
rtl/dtls_ctrl.sv
rtl/dtls_datapath.sv
rtl/decision_tree_leaf_splitter.sv
rtl/dtls_checker.sv
bench/decision_tree_leaf_splitter_tb.sv
